>>> hdl/sms_pkg.sv
// Shared types and constants for the sparse matrix store.
`default_nettype none

package sms_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned COORD_MAX = 255;

  localparam int unsigned COORD_W   = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    TOK_SEARCH = 1'b0,
    TOK_ALLOC  = 1'b1
  } tok_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ALLOC,
    ST_DONE
  } ctrl_state_t;

  // Request token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                       active;
    tok_op_t                    op;
    logic                       write;
    logic                       del;      // written value equals the default
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [VALUE_W-1:0]  value;
    logic                       hit;      // search: cell found; alloc: entry claimed
    logic signed [VALUE_W-1:0]  rd_value;
  } tok_t;

endpackage

`default_nettype wire

>>> hdl/sms_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface sms_cmd_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        mode;
  logic [sms_pkg::COORD_W-1:0]                 row;
  logic [sms_pkg::COORD_W-1:0]                 col;
  logic signed [sms_pkg::VALUE_W-1:0]          value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface sms_rsp_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [sms_pkg::VALUE_W-1:0]          read_value;
  logic [1:0]                                  status;
  logic [sms_pkg::CNT_W-1:0]                   stored_count;

  modport source (output valid, read_value, status, stored_count, input ready);
  modport sink   (input valid, read_value, status, stored_count, output ready);
endinterface

`default_nettype wire

>>> hdl/sms_cell.sv
// One table entry of the chain: compare, update or drop, claim, and pass the token on.
`default_nettype none

module sms_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sms_pkg::tok_t tok_in,
  output sms_pkg::tok_t      tok_out
);

  logic                                valid;
  logic [sms_pkg::COORD_W-1:0]         row;
  logic [sms_pkg::COORD_W-1:0]         col;
  logic signed [sms_pkg::VALUE_W-1:0]  value;

  sms_pkg::tok_t tok_next;
  logic          match;
  logic          claim;
  logic          update;
  logic          drop;

  assign match = valid && (tok_in.row == row) && (tok_in.col == col);

  always_comb begin
    tok_next = tok_in;
    claim    = 1'b0;
    update   = 1'b0;
    drop     = 1'b0;
    if (tok_in.active) begin
      unique case (tok_in.op)
        sms_pkg::TOK_SEARCH: begin
          if (match) begin
            tok_next.hit      = 1'b1;
            tok_next.rd_value = value;
            if (tok_in.write) begin
              drop   = tok_in.del;
              update = !tok_in.del;
            end
          end
        end
        sms_pkg::TOK_ALLOC: begin
          // first free entry along the chain takes the cell
          if (!tok_in.hit && !valid) begin
            claim        = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      valid   <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (claim) begin
        valid <= 1'b1;
        row   <= tok_in.row;
        col   <= tok_in.col;
        value <= tok_in.value;
      end else if (update) begin
        value <= tok_in.value;
      end else if (drop) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sms_ctrl.sv
// Sequencer: config registers, range check, token launch, count and result register.
`default_nettype none

module sms_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  sms_cmd_if.sink                              cmd,
  sms_rsp_if.source                            result,
  input  wire logic                            cfg_we,
  input  wire logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sms_pkg::CFG_W-1:0]       cfg_data,
  output sms_pkg::tok_t                        launch,
  input  wire sms_pkg::tok_t                   tail
);

  logic [sms_pkg::COORD_W-1:0]         num_rows;
  logic [sms_pkg::COORD_W-1:0]         num_cols;
  logic signed [sms_pkg::VALUE_W-1:0]  dflt;

  sms_pkg::ctrl_state_t                state, state_next;
  sms_pkg::tok_t                       req, req_next;
  sms_pkg::tok_t                       launch_next;
  logic [sms_pkg::CNT_W-1:0]           count, count_next;
  logic signed [sms_pkg::VALUE_W-1:0]  res_value, res_value_next;
  sms_pkg::status_t                    res_status, res_status_next;

  logic                                out_valid, out_valid_next;
  logic signed [sms_pkg::VALUE_W-1:0]  out_value, out_value_next;
  sms_pkg::status_t                    out_status, out_status_next;
  logic [sms_pkg::CNT_W-1:0]           out_count, out_count_next;

  logic accept;
  logic in_range;

  assign cmd.ready           = (state == sms_pkg::ST_IDLE);
  assign accept              = cmd.valid && cmd.ready;
  assign result.valid        = out_valid;
  assign result.read_value   = out_value;
  assign result.status       = out_status;
  assign result.stored_count = out_count;

  assign in_range = (cmd.row != '0) && (cmd.row <= num_rows) &&
                    (32'(cmd.row) <= sms_pkg::COORD_MAX) &&
                    (cmd.col != '0) && (cmd.col <= num_cols) &&
                    (32'(cmd.col) <= sms_pkg::COORD_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= '0;
      num_cols <= '0;
      dflt     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sms_pkg::REG_NUM_ROWS:      num_rows <= cfg_data[sms_pkg::COORD_W-1:0];
        sms_pkg::REG_NUM_COLS:      num_cols <= cfg_data[sms_pkg::COORD_W-1:0];
        sms_pkg::REG_DEFAULT_VALUE: dflt     <= cfg_data[sms_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    launch_next     = req;
    launch_next.active = 1'b0;
    count_next      = count;
    res_value_next  = res_value;
    res_status_next = res_status;
    out_valid_next  = out_valid && !result.ready;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_count_next  = out_count;

    unique case (state)
      sms_pkg::ST_IDLE: begin
        if (accept) begin
          req_next.active   = 1'b1;
          req_next.op       = sms_pkg::TOK_SEARCH;
          req_next.write    = cmd.mode;
          req_next.del      = (cmd.value == dflt);
          req_next.row      = cmd.row;
          req_next.col      = cmd.col;
          req_next.value    = cmd.value;
          req_next.hit      = 1'b0;
          req_next.rd_value = '0;
          if (!in_range) begin
            res_value_next  = cmd.mode ? '0 : dflt;
            res_status_next = sms_pkg::STAT_RANGE;
            state_next      = sms_pkg::ST_DONE;
          end else begin
            launch_next = req_next;
            state_next  = sms_pkg::ST_SEARCH;
          end
        end
      end
      sms_pkg::ST_SEARCH: begin
        if (tail.active) begin
          res_status_next = sms_pkg::STAT_OK;
          res_value_next  = '0;
          state_next      = sms_pkg::ST_DONE;
          if (!req.write) begin
            res_value_next = tail.hit ? tail.rd_value : dflt;
          end else if (tail.hit) begin
            if (req.del && count != '0) count_next = count - 1'b1;
          end else if (!req.del) begin
            if (32'(count) == sms_pkg::ENTRIES) begin
              res_status_next = sms_pkg::STAT_FULL;
            end else begin
              // miss with room left: send a claim token down the chain
              launch_next     = req;
              launch_next.op  = sms_pkg::TOK_ALLOC;
              launch_next.hit = 1'b0;
              state_next      = sms_pkg::ST_ALLOC;
            end
          end
        end
      end
      sms_pkg::ST_ALLOC: begin
        if (tail.active) begin
          count_next = count + 1'b1;
          state_next = sms_pkg::ST_DONE;
        end
      end
      sms_pkg::ST_DONE: begin
        // hold until the result register is free or draining
        if (!out_valid || result.ready) begin
          out_valid_next  = 1'b1;
          out_value_next  = res_value;
          out_status_next = res_status;
          out_count_next  = count;
          state_next      = sms_pkg::ST_IDLE;
        end
      end
      default: state_next = sms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sms_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      launch    <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      launch    <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

endmodule

`default_nettype wire

>>> hdl/sparse_matrix_store_top.sv
// A lookup walks the chain of ENTRIES cells, one cell per cycle; a write that misses and
// must insert a new entry walks the chain twice, once to search and once to claim a cell.
// Out-of-range items skip the chain. One item is in flight at a time: a new command is
// accepted only once the controller is idle again, after the result register is loaded.
// Reset (rst, synchronous, active high) clears all entries, the count and the config registers.
`default_nettype none

module sparse_matrix_store_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  sms_cmd_if.sink                              cmd,
  sms_rsp_if.source                            result,
  input  wire logic                            cfg_we,
  input  wire logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sms_pkg::CFG_W-1:0]       cfg_data
);

  sms_pkg::tok_t tok [sms_pkg::ENTRIES+1];

  sms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .launch    (tok[0]),
    .tail      (tok[sms_pkg::ENTRIES])
  );

  for (genvar i = 0; i < sms_pkg::ENTRIES; i++) begin : g_cell
    sms_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

endmodule

`default_nettype wire
